>>> hw/rtl/led_strip_pixel_encoder_assert.svh
// Assertion macros for the LED strip pixel encoder.
`ifndef LED_STRIP_PIXEL_ENCODER_ASSERT_SVH
`define LED_STRIP_PIXEL_ENCODER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define LSPE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LSPE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/lspe_pkg.sv
// Shared types, constants and helpers for the LED strip pixel encoder.
`default_nettype none

package lspe_pkg;

	localparam int LED_COUNT_DEF = 64;
	localparam int CH_W          = 8;
	localparam int PIX_W         = 3 * CH_W;
	localparam int IDX_W         = 6;
	localparam int OP_W          = 2;
	localparam int REG_IDX_W     = 2;
	localparam int DIV_STEPS     = CH_W;
	localparam int CNT_W         = $clog2(PIX_W);

	localparam logic [OP_W-1:0] OP_SET  = 2'd0;
	localparam logic [OP_W-1:0] OP_FILL = 2'd1;
	localparam logic [OP_W-1:0] OP_SEND = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_BRIGHT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ONE    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ZERO   = 2'd2;

	localparam logic [CH_W-1:0] BRIGHT_RST = 8'd1;
	localparam logic [CH_W-1:0] ONE_RST    = 8'hF8;
	localparam logic [CH_W-1:0] ZERO_RST   = 8'hC0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WRITE,
		ST_FILL,
		ST_READ,
		ST_LOAD,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic mem_we;
		logic wr_sweep;
		logic wr_zero;
		logic sweep_inc;
		logic mem_re;
		logic load_shift;
		logic emit;
		logic last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_free;
	} dp_status_t;

	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lspe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lspe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [lspe_pkg::addr_w(DEPTH)-1:0]    waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [lspe_pkg::addr_w(DEPTH)-1:0]    raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/lspe_ctrl.sv
// Controller state machine: sequences clear, divide, store and send.
`default_nettype none

module lspe_ctrl #(
	parameter int LED_COUNT = lspe_pkg::LED_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lspe_pkg::OP_W-1:0]     op,
	input  wire logic [lspe_pkg::IDX_W-1:0]    led_index,
	input  wire lspe_pkg::dp_status_t          status,
	output lspe_pkg::ctrl_cmd_t                cmd
);

	lspe_pkg::state_t                 state_q;
	lspe_pkg::state_t                 state_d;
	logic [lspe_pkg::OP_W-1:0]        op_q;
	logic [lspe_pkg::CNT_W-1:0]       cnt_q;
	logic                             in_range;
	logic                             accept;
	logic                             div_done;
	logic                             send_last;

	assign in_range  = 32'(led_index) < 32'(LED_COUNT);
	assign accept    = in_valid && (state_q == lspe_pkg::ST_IDLE);
	assign in_stall  = (state_q != lspe_pkg::ST_IDLE);
	assign div_done  = (cnt_q == lspe_pkg::CNT_W'(lspe_pkg::DIV_STEPS - 1));
	assign send_last = (cnt_q == lspe_pkg::CNT_W'(lspe_pkg::PIX_W - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			lspe_pkg::ST_CLEAR: begin
				if (status.sweep_last) state_d = lspe_pkg::ST_IDLE;
			end
			lspe_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (op)
						lspe_pkg::OP_SET:  state_d = in_range ? lspe_pkg::ST_DIV : lspe_pkg::ST_IDLE;
						lspe_pkg::OP_FILL: state_d = lspe_pkg::ST_DIV;
						lspe_pkg::OP_SEND: state_d = in_range ? lspe_pkg::ST_READ : lspe_pkg::ST_IDLE;
						default:           state_d = lspe_pkg::ST_IDLE;
					endcase
				end
			end
			lspe_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = (op_q == lspe_pkg::OP_FILL) ? lspe_pkg::ST_FILL : lspe_pkg::ST_WRITE;
				end
			end
			lspe_pkg::ST_WRITE: state_d = lspe_pkg::ST_IDLE;
			lspe_pkg::ST_FILL: begin
				if (status.sweep_last) state_d = lspe_pkg::ST_IDLE;
			end
			lspe_pkg::ST_READ: state_d = lspe_pkg::ST_LOAD;
			lspe_pkg::ST_LOAD: state_d = lspe_pkg::ST_SEND;
			lspe_pkg::ST_SEND: begin
				if (status.out_free && send_last) state_d = lspe_pkg::ST_IDLE;
			end
			default: state_d = lspe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			lspe_pkg::ST_CLEAR: begin
				cmd.mem_we    = 1'b1;
				cmd.wr_sweep  = 1'b1;
				cmd.wr_zero   = 1'b1;
				cmd.sweep_inc = 1'b1;
			end
			lspe_pkg::ST_IDLE:  cmd.capture  = accept;
			lspe_pkg::ST_DIV:   cmd.div_step = 1'b1;
			lspe_pkg::ST_WRITE: cmd.mem_we   = 1'b1;
			lspe_pkg::ST_FILL: begin
				cmd.mem_we    = 1'b1;
				cmd.wr_sweep  = 1'b1;
				cmd.sweep_inc = 1'b1;
			end
			lspe_pkg::ST_READ: cmd.mem_re     = 1'b1;
			lspe_pkg::ST_LOAD: cmd.load_shift = 1'b1;
			lspe_pkg::ST_SEND: begin
				cmd.emit = status.out_free;
				cmd.last = send_last;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lspe_pkg::ST_CLEAR;
			op_q    <= lspe_pkg::OP_SET;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q  <= op;
				cnt_q <= '0;
			end else if (state_q == lspe_pkg::ST_DIV) begin
				cnt_q <= div_done ? '0 : cnt_q + 1'b1;
			end else if (state_q == lspe_pkg::ST_SEND && status.out_free) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lspe_dp.sv
// Datapath: config registers, channel dividers, pixel store, bit shifter, output register.
`default_nettype none

module lspe_dp #(
	parameter int LED_COUNT = lspe_pkg::LED_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lspe_pkg::ctrl_cmd_t                cmd,
	output lspe_pkg::dp_status_t                    status,
	input  wire logic [lspe_pkg::IDX_W-1:0]         led_index,
	input  wire logic [lspe_pkg::CH_W-1:0]          red,
	input  wire logic [lspe_pkg::CH_W-1:0]          green,
	input  wire logic [lspe_pkg::CH_W-1:0]          blue,
	input  wire logic                               cfg_we,
	input  wire logic [lspe_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [lspe_pkg::CH_W-1:0]          cfg_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [lspe_pkg::CH_W-1:0]          code_byte,
	output logic                                    last_of_pixel
);

	localparam int AW    = lspe_pkg::addr_w(LED_COUNT);
	localparam int CH_W  = lspe_pkg::CH_W;
	localparam int PIX_W = lspe_pkg::PIX_W;

	logic [CH_W-1:0]           bright_q;
	logic [CH_W-1:0]           one_q;
	logic [CH_W-1:0]           zero_q;
	logic [lspe_pkg::IDX_W-1:0] idx_q;
	logic [AW-1:0]             sweep_q;
	logic [CH_W-1:0]           divisor;
	logic [CH_W-1:0]           rem_q [3];
	logic [CH_W-1:0]           quo_q [3];
	logic [CH_W:0]             trial [3];
	logic [CH_W:0]             diff  [3];
	logic [PIX_W-1:0]          shift_q;
	logic [PIX_W-1:0]          rd_data;
	logic [PIX_W-1:0]          wr_data;
	logic [AW-1:0]             wr_addr;
	logic                      out_valid_q;
	logic [CH_W-1:0]           code_q;
	logic                      last_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= lspe_pkg::BRIGHT_RST;
			one_q    <= lspe_pkg::ONE_RST;
			zero_q   <= lspe_pkg::ZERO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lspe_pkg::REG_BRIGHT: bright_q <= cfg_data;
				lspe_pkg::REG_ONE:    one_q    <= cfg_data;
				lspe_pkg::REG_ZERO:   zero_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// radix-2 restoring division, one lane per channel: green, red, blue
	assign divisor = (bright_q == '0) ? CH_W'(1) : bright_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], quo_q[i][CH_W-1]};
			diff[i]  = trial[i] - {1'b0, divisor};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q    <= led_index;
			quo_q[0] <= green;
			quo_q[1] <= red;
			quo_q[2] <= blue;
			for (int i = 0; i < 3; i++) rem_q[i] <= '0;
		end else if (cmd.div_step) begin
			for (int i = 0; i < 3; i++) begin
				if (!diff[i][CH_W]) begin
					rem_q[i] <= diff[i][CH_W-1:0];
					quo_q[i] <= {quo_q[i][CH_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= trial[i][CH_W-1:0];
					quo_q[i] <= {quo_q[i][CH_W-2:0], 1'b0};
				end
			end
		end
	end

	// sweep address for clear and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.capture) begin
			sweep_q <= '0;
		end else if (cmd.sweep_inc) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	assign status.sweep_last = (sweep_q == AW'(LED_COUNT - 1));

	assign wr_addr = cmd.wr_sweep ? sweep_q : AW'(idx_q);
	assign wr_data = cmd.wr_zero ? '0 : {quo_q[0], quo_q[1], quo_q[2]};

	lspe_ram #(
		.WIDTH(PIX_W),
		.DEPTH(LED_COUNT)
	) u_store (
		.clk  (clk),
		.we   (cmd.mem_we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (cmd.mem_re),
		.raddr(AW'(idx_q)),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_shift) begin
			shift_q <= rd_data;
		end else if (cmd.emit) begin
			shift_q <= {shift_q[PIX_W-2:0], 1'b0};
		end
	end

	// output register
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			code_q <= shift_q[PIX_W-1] ? one_q : zero_q;
			last_q <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_byte     = code_q;
	assign last_of_pixel = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/led_strip_pixel_encoder.sv
// Top level of the LED strip pixel encoder: controller, datapath and checks.
//
// After reset the block sweeps the pixel store to black, one entry per cycle,
// and takes no item until done. One item is worked on at a time: a set runs
// accept, 8 division steps, store write; a fill runs accept, 8 division steps
// and a write of every store entry (the store has one write port); a send runs
// accept, store read, load, 24 code bytes, one code byte per cycle out of the
// output register unless the output stalls. The brightness division is a
// radix-2 restoring divider, one quotient bit per cycle for all three channels.
`default_nettype none

`include "led_strip_pixel_encoder_assert.svh"

module led_strip_pixel_encoder #(
	parameter int LED_COUNT = lspe_pkg::LED_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [lspe_pkg::OP_W-1:0]          op,
	input  wire logic [lspe_pkg::IDX_W-1:0]         led_index,
	input  wire logic [lspe_pkg::CH_W-1:0]          red,
	input  wire logic [lspe_pkg::CH_W-1:0]          green,
	input  wire logic [lspe_pkg::CH_W-1:0]          blue,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [lspe_pkg::CH_W-1:0]          code_byte,
	output logic                                    last_of_pixel,
	input  wire logic                               cfg_we,
	input  wire logic [lspe_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [lspe_pkg::CH_W-1:0]          cfg_data
);

	lspe_pkg::ctrl_cmd_t  cmd;
	lspe_pkg::dp_status_t status;

	lspe_ctrl #(
		.LED_COUNT(LED_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.led_index(led_index),
		.status   (status),
		.cmd      (cmd)
	);

	lspe_dp #(
		.LED_COUNT(LED_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.led_index    (led_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_byte    (code_byte),
		.last_of_pixel(last_of_pixel)
	);

	`LSPE_ASSERT_IMPL(a_store_write_busy, cmd.mem_we, in_stall, "store write while taking items")
	`LSPE_ASSERT_IMPL(a_emit_free, cmd.emit, status.out_free, "code byte overwrites a pending one")
	`LSPE_ASSERT_IMPL(a_send_busy, $rose(out_valid), in_stall, "pixel started while idle")

endmodule

`default_nettype wire
